>>> hw/rtl/tdpf_pkg.sv
package tdpf_pkg;

    localparam int VALUE_BITS   = 16;
    localparam int COUNT_BITS   = 17;
    // Trial divisors never exceed the square root of the value, plus one spare bit.
    localparam int DIV_BITS     = VALUE_BITS / 2 + 1;
    localparam int SQ_BITS      = VALUE_BITS + 2;
    localparam int BIT_IDX_BITS = $clog2(VALUE_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Outcome of the front-end classification.
    typedef enum logic [1:0] {
        KIND_NOT_PRIME = 2'd0,
        KIND_PRIME     = 2'd1,
        KIND_TEST      = 2'd2
    } tdpf_kind_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        tdpf_kind_t            kind;
    } tdpf_item_t;

endpackage

>>> hw/rtl/tdpf_front.sv
module tdpf_front
    import tdpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    output logic                  push_valid,
    input  logic                  push_ready,
    output tdpf_item_t            push_item
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    tdpf_item_t hold_item_reg;
    tdpf_item_t hold_item_next;
    tdpf_kind_t kind;

    // Values below two are not prime; two and three have no divisor to try.
    always_comb
    begin
        priority if (value < VALUE_BITS'(2))
            kind = KIND_NOT_PRIME;
        else if (value < VALUE_BITS'(4))
            kind = KIND_PRIME;
        else
            kind = KIND_TEST;
    end

    assign in_ready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg && !push_ready;
        hold_item_next  = hold_item_reg;
        if (in_valid && in_ready)
        begin
            hold_valid_next      = 1'b1;
            hold_item_next.value = value;
            hold_item_next.last  = last;
            hold_item_next.kind  = kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        hold_item_reg <= hold_item_next;
    end

endmodule

>>> hw/rtl/tdpf_fifo.sv
module tdpf_fifo
    import tdpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  tdpf_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output tdpf_item_t pop_item
);

    tdpf_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // The pointers differ exactly when the queue holds one entry.
    a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg != rd_ptr_reg) == (fill_reg == 2'd1))
        else $error("queue pointers disagree with fill level");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill level out of range");

endmodule

>>> hw/rtl/tdpf_back.sv
module tdpf_back
    import tdpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  tdpf_item_t            pop_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] value_out,
    output logic                  is_prime,
    output logic [COUNT_BITS-1:0] prime_count,
    output logic                  last_out
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } tdpf_state_t;

    tdpf_state_t             state_reg,  state_next;
    logic [VALUE_BITS-1:0]   val_reg,    val_next;
    logic                    last_reg,   last_next;
    logic                    prime_reg,  prime_next;
    logic [DIV_BITS-1:0]     d_reg,      d_next;
    logic [SQ_BITS-1:0]      sq_reg,     sq_next;
    logic [DIV_BITS-1:0]     rem_reg,    rem_next;
    logic [BIT_IDX_BITS-1:0] bit_reg,    bit_next;
    logic [COUNT_BITS-1:0]   run_reg,    run_next;
    logic                    ov_reg,     ov_next;
    logic [VALUE_BITS-1:0]   ovalue_reg, ovalue_next;
    logic                    oprime_reg, oprime_next;
    logic [COUNT_BITS-1:0]   ocount_reg, ocount_next;
    logic                    olast_reg,  olast_next;

    logic [DIV_BITS-1:0]     shift;
    logic [DIV_BITS-1:0]     rem_step;
    logic [SQ_BITS-1:0]      sq_inc;
    logic [COUNT_BITS-1:0]   count_sum;

    assign pop_ready   = (state_reg == ST_IDLE);
    assign out_valid   = ov_reg;
    assign value_out   = ovalue_reg;
    assign is_prime    = oprime_reg;
    assign prime_count = ocount_reg;
    assign last_out    = olast_reg;

    // One restoring remainder step per cycle, most significant value bit first.
    assign shift    = {rem_reg[DIV_BITS-2:0], val_reg[bit_reg]};
    assign rem_step = (shift >= d_reg) ? (shift - d_reg) : shift;
    // (d + 1)^2 = d^2 + 2d + 1
    assign sq_inc   = sq_reg + {{(SQ_BITS-DIV_BITS-1){1'b0}}, d_reg, 1'b1};
    assign count_sum = (prime_reg && (run_reg != COUNT_MAX)) ? run_reg + COUNT_BITS'(1)
                                                             : run_reg;

    always_comb
    begin
        state_next  = state_reg;
        val_next    = val_reg;
        last_next   = last_reg;
        prime_next  = prime_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        rem_next    = rem_reg;
        bit_next    = bit_reg;
        run_next    = run_reg;
        ov_next     = ov_reg && !out_ready;
        ovalue_next = ovalue_reg;
        oprime_next = oprime_reg;
        ocount_next = ocount_reg;
        olast_next  = olast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    val_next  = pop_item.value;
                    last_next = pop_item.last;
                    d_next    = DIV_BITS'(2);
                    sq_next   = SQ_BITS'(4);
                    rem_next  = '0;
                    bit_next  = BIT_IDX_BITS'(VALUE_BITS - 1);
                    unique case (pop_item.kind)
                        KIND_PRIME:
                        begin
                            prime_next = 1'b1;
                            state_next = ST_DONE;
                        end
                        KIND_TEST:
                        begin
                            prime_next = 1'b0;
                            state_next = ST_DIV;
                        end
                        default:
                        begin
                            prime_next = 1'b0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                bit_next = bit_reg - BIT_IDX_BITS'(1);
                if (bit_reg == '0)
                begin
                    if (rem_step == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (sq_inc > {{(SQ_BITS-VALUE_BITS){1'b0}}, val_reg})
                    begin
                        prime_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next   = d_reg + DIV_BITS'(1);
                        sq_next  = sq_inc;
                        rem_next = '0;
                        bit_next = BIT_IDX_BITS'(VALUE_BITS - 1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    ovalue_next = val_reg;
                    oprime_next = prime_reg;
                    ocount_next = count_sum;
                    olast_next  = last_reg;
                    run_next    = last_reg ? '0 : count_sum;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            run_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        last_reg   <= last_next;
        prime_reg  <= prime_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
        rem_reg    <= rem_next;
        bit_reg    <= bit_next;
        ovalue_reg <= ovalue_next;
        oprime_reg <= oprime_next;
        ocount_reg <= ocount_next;
        olast_reg  <= olast_next;
    end

    // The running square must track the divisor while the loop runs.
    a_square: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |->
        (({{(SQ_BITS-DIV_BITS){1'b0}}, d_reg} * {{(SQ_BITS-DIV_BITS){1'b0}}, d_reg})
            == sq_reg))
        else $error("divisor square out of step");

    // A divisor is only tried while its square does not exceed the value.
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (sq_reg <= {{(SQ_BITS-VALUE_BITS){1'b0}}, val_reg}))
        else $error("trial divisor beyond square root");

    // The partial remainder stays below the divisor.
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < d_reg))
        else $error("partial remainder not reduced");

endmodule

>>> hw/rtl/trial_division_prime_filter.sv
// Trial-division prime filter. Each input transaction carries an unsigned 16-bit value and a
// last-of-list mark; exactly one output transaction comes back per input, in order, holding
// the value, a prime flag (0 and 1 are not prime) and the count of primes seen so far in the
// current list, this item included, saturating at 2^17-1. The count returns to zero after the
// item marked last. The front end registers and classifies each value, a two-entry queue
// decouples it from the back end, and the back end runs the trial divisions with a single
// restoring remainder unit that retires one value bit per cycle. Values below four need no
// division. A larger value runs one full pass over its value bits for every divisor tried,
// divisors running from 2 up to the first exact divisor or to the square root, so an even
// value tries a single divisor, and a prime above 65025 tries 254 divisors, which is the
// worst case. The output is registered, so a finished result can wait for the consumer while
// the front end keeps taking new transactions into the queue until it fills.
module trial_division_prime_filter
    import tdpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] value_out,
    output logic                  is_prime,
    output logic [COUNT_BITS-1:0] prime_count,
    output logic                  last_out
);

    logic       push_valid;
    logic       push_ready;
    tdpf_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    tdpf_item_t pop_item;

    // Front end: accepts the transaction and sorts out the trivial values.
    tdpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .last       (last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Short queue so that either side can stall without holding up the other.
    tdpf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back end: trial division, list count and the output register.
    tdpf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value_out   (value_out),
        .is_prime    (is_prime),
        .prime_count (prime_count),
        .last_out    (last_out)
    );

endmodule
